/* src/pmst_pkg.sv */
// ----------------------------------------------------------------------------
// pmst_pkg
// Shared widths, codes and beat types of the minimum spanning tree engine.
// ----------------------------------------------------------------------------
package pmst_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int V_AW         = $clog2(MAX_VERTICES);
    localparam int N_W          = V_AW + 1;
    localparam int MAX_EDGES    = 8192;
    localparam int E_AW         = $clog2(MAX_EDGES);
    localparam int EU_W         = E_AW + 1;
    localparam int WEIGHT_BITS  = 16;
    localparam int KEY_W        = WEIGHT_BITS + 1;
    localparam int TOTAL_W      = 26;
    localparam int TREE_W       = 10;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 11;

    localparam logic [KEY_W-1:0] KEY_INF = KEY_W'(1) << WEIGHT_BITS;

    // commands
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 1'b1;

    typedef struct packed {
        logic [1:0]             command;
        logic [V_AW-1:0]        from_vertex;
        logic [V_AW-1:0]        to_vertex;
        logic [WEIGHT_BITS-1:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [TOTAL_W-1:0]     total_weight;
        logic [WEIGHT_BITS-1:0] heavy_edge;
        logic [TREE_W-1:0]      tree_edges;
        logic                   complete;
    } out_item_t;

    typedef struct packed {
        logic            valid;
        logic [E_AW-1:0] head;
        logic [E_AW-1:0] tail;
    } list_entry_t;

    typedef struct packed {
        logic                   pending;
        logic                   has_parent;
        logic [KEY_W-1:0]       key;
    } vertex_entry_t;

    typedef struct packed {
        logic [V_AW-1:0]        target;
        logic [WEIGHT_BITS-1:0] weight;
    } edge_entry_t;

endpackage

/* src/pmst_ram.sv */
// ----------------------------------------------------------------------------
// pmst_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pmst_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/prim_minimum_spanning_tree_top.sv */
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_top
// Edge store and Prim spanning tree engine over per-vertex RAMs.
// ----------------------------------------------------------------------------
// One beat in, one beat out, one item at a time. A clear sweeps the 1024
// list entries, one a cycle; the same sweep runs after reset, and no beat
// is taken until it ends. An add writes the edge and its list entry and,
// into a non-empty list, then links the old tail to it, before the result
// is handed over; a rejected add or an unused command goes straight to the
// response. A run works through the vertex RAM, which has a single read
// port: it sets up the keys, then for each of the n extractions it scans
// for the least pending key, marks that vertex, fetches its list, relaxes
// each out-edge in turn and advances to the next extraction; a final sum
// pass over the vertex RAM then gathers the result.
// A finished result waits in the output register while the next beat is
// taken.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pmst_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output pmst_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pmst_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmst_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [13:0] {
        S_CLEAR     = 14'b00000000000001,
        S_IDLE      = 14'b00000000000010,
        S_ADD_WR    = 14'b00000000000100,
        S_ADD_LINK  = 14'b00000000001000,
        S_INIT      = 14'b00000000010000,
        S_SCAN      = 14'b00000000100000,
        S_EXTRACT   = 14'b00000001000000,
        S_LIST      = 14'b00000010000000,
        S_EDGE_RD   = 14'b00000100000000,
        S_EDGE_DATA = 14'b00001000000000,
        S_VERT_DATA = 14'b00010000000000,
        S_NEXT      = 14'b00100000000000,
        S_SUM       = 14'b01000000000000,
        S_RESP      = 14'b10000000000000
    } state_t;

    localparam int V_AW = pmst_pkg::V_AW;
    localparam int N_W  = pmst_pkg::N_W;
    localparam int E_AW = pmst_pkg::E_AW;
    localparam int W_B  = pmst_pkg::WEIGHT_BITS;

    // control state
    state_t                       state_reg, state_next;
    logic [N_W-1:0]               cnt_reg, cnt_next;
    logic [N_W-1:0]               step_reg, step_next;
    logic [N_W-1:0]               vcount_reg, vcount_next;
    logic [V_AW-1:0]              start_reg, start_next;
    logic [pmst_pkg::EU_W-1:0]    edges_used_reg, edges_used_next;
    logic                         clr_resp_reg, clr_resp_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic                         best_found_reg, best_found_next;
    logic                         out_valid_reg, out_valid_next;

    // payload
    pmst_pkg::in_item_t           hold_reg, hold_next;
    logic [V_AW-1:0]              best_idx_reg, best_idx_next;
    pmst_pkg::vertex_entry_t      best_reg, best_next;
    logic [V_AW-1:0]              rd_idx_reg, rd_idx_next;
    logic [E_AW-1:0]              edge_reg, edge_next;
    logic [E_AW-1:0]              tail_reg, tail_next;
    logic [E_AW-1:0]              link_reg, link_next;
    logic [V_AW-1:0]              tgt_reg, tgt_next;
    logic                         tgt_ok_reg, tgt_ok_next;
    logic [W_B-1:0]               wt_reg, wt_next;
    logic [pmst_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [W_B-1:0]               max_reg, max_next;
    logic [N_W-1:0]               nz_reg, nz_next;
    pmst_pkg::out_item_t          result_reg, result_next;
    pmst_pkg::out_item_t          out_data_reg, out_data_next;

    // RAM ports
    logic                         list_we;
    logic [V_AW-1:0]              list_waddr, list_raddr;
    pmst_pkg::list_entry_t        list_wdata, list_rdata;
    logic                         vert_we;
    logic [V_AW-1:0]              vert_waddr, vert_raddr;
    pmst_pkg::vertex_entry_t      vert_wdata, vert_rdata;
    logic                         tw_we;
    pmst_pkg::edge_entry_t        tw_wdata, tw_rdata;
    logic                         link_we;
    logic [E_AW-1:0]              link_waddr, link_wdata, link_rdata;

    logic [N_W-1:0]               n_used;
    logic                         accept;
    logic                         cnt_run;

    // vertex count in force: zero reads as one, oversize clamps
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_used = N_W'(1);
        end
        else if (vcount_reg > N_W'(pmst_pkg::MAX_VERTICES))
        begin
            n_used = N_W'(pmst_pkg::MAX_VERTICES);
        end
        else
        begin
            n_used = vcount_reg;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cnt_run   = (cnt_reg < n_used);

    // read addresses: lists are looked up by the arriving beat or the
    // extracted vertex; vertex reads follow the stream counter except
    // when fetching an edge target
    assign list_raddr = (state_reg == S_IDLE) ? in_data.from_vertex : best_idx_reg;
    assign vert_raddr = (state_reg == S_EDGE_DATA) ? tw_rdata.target : cnt_reg[V_AW-1:0];

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        vcount_next     = vcount_reg;
        start_next      = start_reg;
        edges_used_next = edges_used_reg;
        clr_resp_next   = clr_resp_reg;
        rd_vld_next     = 1'b0;
        best_found_next = best_found_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        hold_next       = hold_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        rd_idx_next     = cnt_reg[V_AW-1:0];
        edge_next       = edge_reg;
        tail_next       = tail_reg;
        link_next       = link_reg;
        tgt_next        = tgt_reg;
        tgt_ok_next     = tgt_ok_reg;
        wt_next         = wt_reg;
        total_next      = total_reg;
        max_next        = max_reg;
        nz_next         = nz_reg;
        result_next     = result_reg;
        out_data_next   = out_data_reg;

        list_we    = 1'b0;
        list_waddr = hold_reg.from_vertex;
        list_wdata = '0;
        vert_we    = 1'b0;
        vert_waddr = cnt_reg[V_AW-1:0];
        vert_wdata = '0;
        tw_we      = 1'b0;
        tw_wdata   = '{target: hold_reg.to_vertex, weight: hold_reg.weight};
        link_we    = 1'b0;
        link_waddr = edges_used_reg[E_AW-1:0];
        link_wdata = edges_used_reg[E_AW-1:0];

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pmst_pkg::CFG_VERTEX_COUNT: vcount_next = cfg_data;
                pmst_pkg::CFG_START_VERTEX: start_next  = cfg_data[V_AW-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_CLEAR:
            begin
                // drop every list, one entry a cycle
                list_we    = 1'b1;
                list_waddr = cnt_reg[V_AW-1:0];
                cnt_next   = cnt_reg + N_W'(1);
                if (cnt_reg == N_W'(pmst_pkg::MAX_VERTICES - 1))
                begin
                    state_next    = clr_resp_reg ? S_RESP : S_IDLE;
                    clr_resp_next = 1'b0;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    hold_next   = in_data;
                    result_next = '0;
                    case (in_data.command)
                        pmst_pkg::CMD_CLEAR:
                        begin
                            cnt_next        = '0;
                            clr_resp_next   = 1'b1;
                            edges_used_next = '0;
                            state_next      = S_CLEAR;
                        end
                        pmst_pkg::CMD_ADD:
                        begin
                            if ({1'b0, in_data.from_vertex} >= n_used ||
                                {1'b0, in_data.to_vertex} >= n_used)
                            begin
                                result_next.status = pmst_pkg::ST_RANGE;
                                state_next         = S_RESP;
                            end
                            else if (edges_used_reg[pmst_pkg::EU_W-1])
                            begin
                                result_next.status = pmst_pkg::ST_FULL;
                                state_next         = S_RESP;
                            end
                            else
                            begin
                                state_next = S_ADD_WR;
                            end
                        end
                        pmst_pkg::CMD_RUN:
                        begin
                            if ({1'b0, start_reg} >= n_used)
                            begin
                                result_next.status = pmst_pkg::ST_RANGE;
                                state_next         = S_RESP;
                            end
                            else
                            begin
                                cnt_next   = '0;
                                state_next = S_INIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_ADD_WR:
            begin
                // store the edge as its own tail and append it to the list
                tw_we      = 1'b1;
                link_we    = 1'b1;
                list_we    = 1'b1;
                edge_next  = edges_used_reg[E_AW-1:0];
                tail_next  = list_rdata.tail;
                list_wdata = '{valid: 1'b1,
                               head: list_rdata.valid ? list_rdata.head
                                                      : edges_used_reg[E_AW-1:0],
                               tail: edges_used_reg[E_AW-1:0]};
                edges_used_next = edges_used_reg + pmst_pkg::EU_W'(1);
                state_next      = list_rdata.valid ? S_ADD_LINK : S_RESP;
            end

            S_ADD_LINK:
            begin
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = edge_reg;
                state_next = S_RESP;
            end

            S_INIT:
            begin
                vert_we    = 1'b1;
                vert_wdata = '{pending: 1'b1, has_parent: 1'b0,
                               key: (cnt_reg[V_AW-1:0] == start_reg) ? '0
                                                                     : pmst_pkg::KEY_INF};
                cnt_next = cnt_reg + N_W'(1);
                if (cnt_reg == n_used - N_W'(1))
                begin
                    cnt_next        = '0;
                    step_next       = '0;
                    best_found_next = 1'b0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // stream the vertex RAM, keep the first pending least key
                rd_vld_next = cnt_run;
                if (cnt_run)
                begin
                    cnt_next = cnt_reg + N_W'(1);
                end
                if (rd_vld_reg && vert_rdata.pending &&
                    (!best_found_reg || vert_rdata.key < best_reg.key))
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = rd_idx_reg;
                    best_next       = vert_rdata;
                end
                if (!cnt_run && !rd_vld_reg)
                begin
                    state_next = S_EXTRACT;
                end
            end

            S_EXTRACT:
            begin
                if (!best_found_reg)
                begin
                    cnt_next   = '0;
                    total_next = '0;
                    max_next   = '0;
                    nz_next    = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    vert_we    = 1'b1;
                    vert_waddr = best_idx_reg;
                    vert_wdata = '{pending: 1'b0, has_parent: best_reg.has_parent,
                                   key: best_reg.key};
                    state_next = S_LIST;
                end
            end

            S_LIST:
            begin
                edge_next  = list_rdata.head;
                tail_next  = list_rdata.tail;
                state_next = list_rdata.valid ? S_EDGE_RD : S_NEXT;
            end

            S_EDGE_RD:
            begin
                state_next = S_EDGE_DATA;
            end

            S_EDGE_DATA:
            begin
                tgt_next    = tw_rdata.target;
                wt_next     = tw_rdata.weight;
                link_next   = link_rdata;
                tgt_ok_next = ({1'b0, tw_rdata.target} < n_used);
                state_next  = S_VERT_DATA;
            end

            S_VERT_DATA:
            begin
                // relax: a strictly lighter edge to a pending vertex wins
                if (tgt_ok_reg && vert_rdata.pending &&
                    {1'b0, wt_reg} < vert_rdata.key)
                begin
                    vert_we    = 1'b1;
                    vert_waddr = tgt_reg;
                    vert_wdata = '{pending: 1'b1, has_parent: 1'b1,
                                   key: {1'b0, wt_reg}};
                end
                if (edge_reg == tail_reg)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    edge_next  = link_reg;
                    state_next = S_EDGE_RD;
                end
            end

            S_NEXT:
            begin
                step_next       = step_reg + N_W'(1);
                cnt_next        = '0;
                best_found_next = 1'b0;
                total_next      = '0;
                max_next        = '0;
                nz_next         = '0;
                state_next      = (step_reg == n_used - N_W'(1)) ? S_SUM : S_SCAN;
            end

            S_SUM:
            begin
                rd_vld_next = cnt_run;
                if (cnt_run)
                begin
                    cnt_next = cnt_reg + N_W'(1);
                end
                if (rd_vld_reg && vert_rdata.has_parent)
                begin
                    total_next = total_reg + pmst_pkg::TOTAL_W'(vert_rdata.key[W_B-1:0]);
                    if (max_reg < vert_rdata.key[W_B-1:0])
                    begin
                        max_next = vert_rdata.key[W_B-1:0];
                    end
                    if (vert_rdata.key != '0)
                    begin
                        nz_next = nz_reg + N_W'(1);
                    end
                end
                if (!cnt_run && !rd_vld_reg)
                begin
                    result_next = '{status: pmst_pkg::ST_OK,
                                    total_weight: total_reg,
                                    heavy_edge: max_reg,
                                    tree_edges: nz_reg[pmst_pkg::TREE_W-1:0],
                                    complete: (nz_reg + N_W'(1) == n_used)};
                    state_next  = S_RESP;
                end
            end

            S_RESP:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = result_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cnt_reg        <= '0;
            step_reg       <= '0;
            vcount_reg     <= N_W'(pmst_pkg::MAX_VERTICES);
            start_reg      <= '0;
            edges_used_reg <= '0;
            clr_resp_reg   <= 1'b0;
            rd_vld_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            step_reg       <= step_next;
            vcount_reg     <= vcount_next;
            start_reg      <= start_next;
            edges_used_reg <= edges_used_next;
            clr_resp_reg   <= clr_resp_next;
            rd_vld_reg     <= rd_vld_next;
            best_found_reg <= best_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        rd_idx_reg   <= rd_idx_next;
        edge_reg     <= edge_next;
        tail_reg     <= tail_next;
        link_reg     <= link_next;
        tgt_reg      <= tgt_next;
        tgt_ok_reg   <= tgt_ok_next;
        wt_reg       <= wt_next;
        total_reg    <= total_next;
        max_reg      <= max_next;
        nz_reg       <= nz_next;
        result_reg   <= result_next;
        out_data_reg <= out_data_next;
    end

    pmst_ram #(
        .ADDR_W (V_AW),
        .DATA_W ($bits(pmst_pkg::list_entry_t))
    ) u_list_ram (
        .clk     (clk),
        .wr_en   (list_we),
        .wr_addr (list_waddr),
        .wr_data (list_wdata),
        .rd_addr (list_raddr),
        .rd_data (list_rdata)
    );

    pmst_ram #(
        .ADDR_W (V_AW),
        .DATA_W ($bits(pmst_pkg::vertex_entry_t))
    ) u_vertex_ram (
        .clk     (clk),
        .wr_en   (vert_we),
        .wr_addr (vert_waddr),
        .wr_data (vert_wdata),
        .rd_addr (vert_raddr),
        .rd_data (vert_rdata)
    );

    pmst_ram #(
        .ADDR_W (E_AW),
        .DATA_W ($bits(pmst_pkg::edge_entry_t))
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (tw_we),
        .wr_addr (edges_used_reg[E_AW-1:0]),
        .wr_data (tw_wdata),
        .rd_addr (edge_reg),
        .rd_data (tw_rdata)
    );

    pmst_ram #(
        .ADDR_W (E_AW),
        .DATA_W (E_AW)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_waddr),
        .wr_data (link_wdata),
        .rd_addr (edge_reg),
        .rd_data (link_rdata)
    );

endmodule

/* src/pmst_checker.sv */
// ----------------------------------------------------------------------------
// pmst_props
// Port-level checks of the spanning tree engine, bound to the top level.
// ----------------------------------------------------------------------------
module pmst_props (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  pmst_pkg::in_item_t                  in_data,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  pmst_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [pmst_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmst_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // an error beat carries no tree figures
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != pmst_pkg::ST_OK |->
            out_data.total_weight == '0 && out_data.heavy_edge == '0 &&
            out_data.tree_edges == '0 && !out_data.complete)
        else $error("error beat with tree figures");

    // no heavy edge means no weight
    a_max_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.heavy_edge == '0 |-> out_data.total_weight == '0)
        else $error("total weight without heaviest edge");

    // no nonzero edge means no weight
    a_cnt_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.tree_edges == '0 |-> out_data.total_weight == '0)
        else $error("total weight without counted edges");

endmodule

bind prim_minimum_spanning_tree_top pmst_props u_pmst_checker (.*);
